// ===== src/bda_pkg.sv =====
// Package for the binary to decimal ASCII unit: widths, defaults and the
// digit to character mapping. No dependencies.
package bda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 10;
  localparam int IN_TDATA_W     = 32;
  localparam int CHAR_W         = 6;
  localparam int OUT_TDATA_W    = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DIGIT_BASE     = 10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] nib);
    logic [3:0] dec;
    dec = (nib >= 4'(DIGIT_BASE)) ? nib - 4'(DIGIT_BASE) : nib;
    return ASCII_ZERO + CHAR_W'(dec);
  endfunction

endpackage

// ===== src/binary_to_decimal_ascii_unit.sv =====
// Top level of the binary to decimal ASCII unit: front queue and back
// converter. Uses bda_pkg, bda_front and bda_back.
//
// Each request on the in_ stream carries an unsigned binary value; the unit
// returns its decimal digits as ASCII characters on the out_ stream, most
// significant first, without leading zeros, with tlast on the final digit
// (zero gives the single digit '0'). Conversion is double dabble, one bit per
// cycle, with a digit search after it; the digits then leave one at a time
// as the output takes them. A two-entry queue ahead of the converter takes
// new requests while it works, and the output register lets the converter
// start the next value while the last digit waits.
module binary_to_decimal_ascii_unit
  import bda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic                   out_tlast
);

  logic                  q_valid, q_ready;
  logic [VALUE_BITS-1:0] q_value;
  logic [CHAR_W-1:0]     out_char;

  bda_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_value   (q_value)
  );

  bda_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_value    (q_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, out_char};

endmodule

// ===== src/bda_front.sv =====
// Front part of the binary to decimal ASCII unit: takes requests, trims or
// zero-extends the value to its working width and holds them in a short queue. Uses bda_pkg.
module bda_front
  import bda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [VALUE_BITS-1:0] q_value
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] value_trim;
  logic [VALUE_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  push, pop;

  generate
    if (VALUE_BITS <= IN_TDATA_W) begin : g_trim
      assign value_trim = in_tdata[VALUE_BITS-1:0];
    end else begin : g_ext
      assign value_trim = {{(VALUE_BITS-IN_TDATA_W){1'b0}}, in_tdata};
    end
  endgenerate

  assign in_tready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_value   = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= value_trim;
    end
  end

endmodule

// ===== src/bda_back.sv =====
// Back part of the binary to decimal ASCII unit: double dabble conversion,
// one bit per cycle, then digit output through a register. Uses bda_pkg.
module bda_back
  import bda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [VALUE_BITS-1:0] q_value,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  out_last
);

  localparam int STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int IDX_W  = $clog2(MAX_DIGITS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [3:0]            bcd_r [MAX_DIGITS];
  logic [3:0]            bcd_nxt [MAX_DIGITS];
  logic [VALUE_BITS-1:0] src_r;
  logic [STEP_W-1:0]     step_r;
  logic [IDX_W-1:0]      idx_r, top_idx;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;
  logic                  out_free, load;

  assign out_free   = !out_valid_r || out_tready;
  assign load       = (state_r == ST_EMIT) && out_free;
  assign q_ready    = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

  always_comb begin
    logic       carry;
    logic [4:0] adj;
    carry = src_r[VALUE_BITS-1];
    for (int d = 0; d < MAX_DIGITS; d++) begin
      adj        = {1'b0, bcd_r[d]} + ((bcd_r[d] >= 4'd5) ? 5'd3 : 5'd0);
      bcd_nxt[d] = {adj[2:0], carry};
      carry      = adj[3];
    end
  end

  always_comb begin
    top_idx = '0;
    for (int d = 1; d < MAX_DIGITS; d++) begin
      if (bcd_r[d] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_CONV;
      ST_CONV: if (step_r == STEP_W'(VALUE_BITS - 1)) state_nxt = ST_FIND;
      ST_FIND: state_nxt = ST_EMIT;
      ST_EMIT: if (load && idx_r == '0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        src_r  <= q_value;
        step_r <= '0;
        for (int d = 0; d < MAX_DIGITS; d++) begin
          bcd_r[d] <= 4'd0;
        end
      end
      ST_CONV: begin
        src_r  <= src_r << 1;
        step_r <= step_r + STEP_W'(1);
        bcd_r  <= bcd_nxt;
      end
      ST_FIND: idx_r <= top_idx;
      ST_EMIT: begin
        if (load) begin
          out_char_r <= to_ascii(bcd_r[idx_r]);
          out_last_r <= (idx_r == '0);
          idx_r      <= idx_r - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  a_conv_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (step_r <= STEP_W'(VALUE_BITS - 1)))
    else $error("conversion ran past its step count");

  a_find_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND) |=> (state_r == ST_EMIT))
    else $error("digit search did not lead to output");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && idx_r == '0) |=> (state_r == ST_IDLE && out_last_r))
    else $error("last digit did not end the run");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r >= ASCII_ZERO &&
                     out_char_r <= ASCII_ZERO + CHAR_W'(DIGIT_BASE - 1)))
    else $error("output character is not a decimal digit");

endmodule

// ===== tb/binary_to_decimal_ascii_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for binary_to_decimal_ascii_unit: streams unsigned values in and
// checks every returned ASCII digit and tlast against a local decimal model.
// Depends on bda_pkg and the unit itself.
module binary_to_decimal_ascii_unit_tb
  import bda_pkg::*;
();

  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;  // [31:0] value
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [5:0] digit_char, [7:6] zero
  logic                   out_tlast;

  digit_t pending_digits[$];
  bit     no_gaps = 1'b0;
  int     error_count = 0;
  int     values_sent = 0;
  int     digits_checked = 0;
  int     idle_cycles = 0;

  binary_to_decimal_ascii_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected digit stream of one value, most significant digit first
  function automatic void push_decimal_digits(input logic [IN_TDATA_W-1:0] value);
    logic [3:0]            decimal[MAX_DIGITS_DEF];
    logic [IN_TDATA_W-1:0] rest;
    int                    count;
    digit_t                d;
    rest  = value;
    count = 0;
    do begin
      decimal[count] = 4'(rest % DIGIT_BASE);
      rest           = rest / DIGIT_BASE;
      count++;
    end while (rest != 0 && count < MAX_DIGITS_DEF);
    for (int i = count - 1; i >= 0; i--) begin
      d.digit_char = ASCII_ZERO + CHAR_W'(decimal[i]);
      d.last_digit = (i == 0);
      pending_digits.push_back(d);
    end
  endfunction

  task automatic send_value(input logic [IN_TDATA_W-1:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    push_decimal_digits(value);
    values_sent++;
  endtask

  // hold the input idle until every expected digit has come back
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [IN_TDATA_W-1:0] random_value();
    logic [IN_TDATA_W-1:0] value;
    logic [IN_TDATA_W-1:0] pow10;
    int                    bits;
    if ($urandom_range(0, 4) == 0) begin
      pow10 = 1;
      repeat ($urandom_range(0, 9)) pow10 = pow10 * DIGIT_BASE;
      value = pow10 + IN_TDATA_W'($urandom_range(0, 2)) - 1;
    end else begin
      bits  = $urandom_range(1, IN_TDATA_W);
      value = $urandom;
      if (bits < IN_TDATA_W) value = value & ((IN_TDATA_W'(1) << bits) - 1);
    end
    return value;
  endfunction

  task automatic test_directed();
    logic [IN_TDATA_W-1:0] values[] = '{
      32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd19, 32'd99, 32'd100,
      32'd999999999, 32'd1000000000, 32'd1234567890, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE,
      32'hFFFF_FFFF, 32'd0, 32'd4000000000, 32'd65536
    };
    foreach (values[i]) send_value(values[i]);
    wait_for_drain();
  endtask

  task automatic test_random_values(input int count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_back_to_back(input int count);
    no_gaps = 1'b1;
    repeat (count) send_value(random_value());
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_then_resume(input int count);
    wait_for_drain();
    repeat (count) send_value(random_value());
  endtask

  initial begin : result_checker
    digit_t exp_digit;
    int     gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      digits_checked++;
      if (pending_digits.size() == 0) begin
        $error("unexpected digit: digit_char %0d, last_digit %0b",
               out_tdata[CHAR_W-1:0], out_tlast);
        error_count++;
      end else begin
        exp_digit = pending_digits.pop_front();
        if (out_tdata[CHAR_W-1:0] !== exp_digit.digit_char) begin
          $error("digit_char: expected %0d, got %0d",
                 exp_digit.digit_char, out_tdata[CHAR_W-1:0]);
          error_count++;
        end
        if (out_tlast !== exp_digit.last_digit) begin
          $error("last_digit: expected %0b, got %0b", exp_digit.last_digit, out_tlast);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:CHAR_W] !== '0) begin
          $error("pad: expected 0, got %0d", out_tdata[OUT_TDATA_W-1:CHAR_W]);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout after %0d idle cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_values(200);
    test_back_to_back(80);
    test_pause_then_resume(40);
    test_random_values(70);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_digits.size() != 0) begin
      $error("%0d expected digits never arrived", pending_digits.size());
      error_count++;
    end
    $display("converted %0d values into %0d checked digits", values_sent, digits_checked);
    $display("covered zero, all-ones, power-of-ten edges, random widths and idle/burst mixes");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
